// File: rtl/core/palette_blend_ramp_entry_unit_assert.svh
// assertion macros for the palette blend ramp entry unit
`ifndef PALETTE_BLEND_RAMP_ENTRY_UNIT_ASSERT_SVH
`define PALETTE_BLEND_RAMP_ENTRY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define PBRE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define PBRE_ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) else $error(msg);
`else
`define PBRE_ASSERT(lbl, clk, rstn, prop, msg)
`define PBRE_ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg)
`endif

`endif

// File: rtl/core/pbre_pkg.sv
// types, constants and helper functions shared by the palette blend ramp entry unit
package pbre_pkg;

  // palette shape
  localparam int unsigned GREY_LEVELS = 256;
  localparam int unsigned CUBE_STEPS  = 8;
  localparam int unsigned MAX_LEVELS  = 64;
  localparam int unsigned CUBE_BASE   = CUBE_STEPS + 1;
  localparam int unsigned FULL_SCALE  = 255;
  localparam int unsigned ROUND_HALF  = 128;

  // field widths
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned SHRINK_W = 4;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned LEV_W    = $clog2(MAX_LEVELS + 1);
  localparam int unsigned DIGIT_W  = $clog2(CUBE_BASE);
  localparam int unsigned GQ_W     = $clog2(GREY_LEVELS + 1);

  // index split into base CUBE_BASE digits by reciprocal multiply
  localparam int unsigned CSHIFT    = 20;
  localparam int unsigned SPLIT_P_W = IDX_W + CSHIFT;
  localparam int unsigned RECIP_B1  = ((1 << CSHIFT) + CUBE_BASE - 1) / CUBE_BASE;
  localparam int unsigned RECIP_B2  =
    ((1 << CSHIFT) + CUBE_BASE * CUBE_BASE - 1) / (CUBE_BASE * CUBE_BASE);
  localparam int unsigned RECIP_B3  =
    ((1 << CSHIFT) + CUBE_BASE * CUBE_BASE * CUBE_BASE - 1) /
    (CUBE_BASE * CUBE_BASE * CUBE_BASE);

  // blend divide by levels
  localparam int unsigned DIV_SHIFT = 20;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned NUM_W     = CH_W + LEV_W;
  localparam int unsigned DPROD_W   = NUM_W + RECIP_W;

  // quantizer divide by full scale
  localparam int unsigned QSHIFT  = 24;
  localparam int unsigned QRECIP  = ((1 << QSHIFT) + FULL_SCALE - 1) / FULL_SCALE;
  localparam int unsigned QX_W    = CH_W + $clog2(GREY_LEVELS) + 1;
  localparam int unsigned QPROD_W = 2 * QX_W;

  // queue sizes
  localparam int unsigned MQ_DEPTH  = 4;
  localparam int unsigned MQ_PTR_W  = $clog2(MQ_DEPTH);
  localparam int unsigned MQ_CNT_W  = $clog2(MQ_DEPTH + 1);
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OQ_PTR_W  = $clog2(OUT_DEPTH);
  localparam int unsigned OQ_CNT_W  = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0]    fg_index;
    logic [IDX_W-1:0]    bg_index;
    logic [SHRINK_W-1:0] shrink;
    logic [POS_W-1:0]    position;
  } pbre_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic             position_bad;
  } pbre_out_t;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic             is_grey;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] q1;
    logic [IDX_W-1:0] q2;
    logic [IDX_W-1:0] q3;
  } idx_split_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               position_bad;
    logic [POS_W-1:0]   position;
    logic [LEV_W-1:0]   levels;
    logic [RECIP_W-1:0] recip;
    rgb_t               fg_rgb;
    rgb_t               bg_rgb;
  } pbre_job_t;

  function automatic logic [LEV_W-1:0] levels_of(input logic [SHRINK_W-1:0] s);
    logic [2*SHRINK_W-1:0] sq;
    sq = (2*SHRINK_W)'(s) * (2*SHRINK_W)'(s);
    if (sq > (2*SHRINK_W)'(MAX_LEVELS)) begin
      sq = (2*SHRINK_W)'(MAX_LEVELS);
    end
    if (sq == '0) begin
      sq = (2*SHRINK_W)'(1);
    end
    return LEV_W'(sq);
  endfunction

  function automatic logic [CH_W-1:0] grey_value(input logic [IDX_W-1:0] idx);
    logic [IDX_W+CH_W-1:0] p;
    p = (IDX_W+CH_W)'(idx) * (IDX_W+CH_W)'(FULL_SCALE);
    return CH_W'(p / GREY_LEVELS);
  endfunction

  function automatic logic [CH_W-1:0] digit_value(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W+CH_W-1:0] p;
    p = (DIGIT_W+CH_W)'(d) * (DIGIT_W+CH_W)'(FULL_SCALE);
    return CH_W'(p / CUBE_STEPS);
  endfunction

  function automatic idx_split_t split_index(input logic [IDX_W-1:0] idx);
    idx_split_t s;
    logic [SPLIT_P_W-1:0] p1;
    logic [SPLIT_P_W-1:0] p2;
    logic [SPLIT_P_W-1:0] p3;
    s.idx     = idx;
    s.is_grey = (idx <= IDX_W'(GREY_LEVELS));
    s.c       = idx - IDX_W'(GREY_LEVELS + 1);
    p1        = SPLIT_P_W'(s.c) * SPLIT_P_W'(RECIP_B1);
    p2        = SPLIT_P_W'(s.c) * SPLIT_P_W'(RECIP_B2);
    p3        = SPLIT_P_W'(s.c) * SPLIT_P_W'(RECIP_B3);
    s.q1      = IDX_W'(p1 >> CSHIFT);
    s.q2      = IDX_W'(p2 >> CSHIFT);
    s.q3      = IDX_W'(p3 >> CSHIFT);
    return s;
  endfunction

  function automatic rgb_t decode_rgb(input idx_split_t s);
    rgb_t rgb;
    logic [IDX_W-1:0] bd;
    logic [IDX_W-1:0] gd;
    logic [IDX_W-1:0] rd;
    bd = s.c - s.q1 * IDX_W'(CUBE_BASE);
    gd = s.q1 - s.q2 * IDX_W'(CUBE_BASE);
    // red digit wraps for indices past the cube
    rd = s.q2 - s.q3 * IDX_W'(CUBE_BASE);
    if (s.is_grey) begin
      rgb[0] = grey_value(s.idx);
      rgb[1] = rgb[0];
      rgb[2] = rgb[0];
    end else begin
      rgb[0] = digit_value(DIGIT_W'(rd));
      rgb[1] = digit_value(DIGIT_W'(gd));
      rgb[2] = digit_value(DIGIT_W'(bd));
    end
    return rgb;
  endfunction

  // (x + 0) / 255 by reciprocal, exact over the quantizer range
  function automatic logic [GQ_W-1:0] div_full_scale(input logic [QX_W-1:0] x);
    logic [QPROD_W-1:0] p;
    p = QPROD_W'(x) * QPROD_W'(QRECIP);
    return GQ_W'(p >> QSHIFT);
  endfunction

endpackage

// File: rtl/core/pbre_front.sv
// front end: accepts items, decodes both indices and works out levels and range check
`include "palette_blend_ramp_entry_unit_assert.svh"

module pbre_front import pbre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  pbre_in_t  data_i,
  input  logic      credit_i,
  output logic      job_valid_o,
  output pbre_job_t job_o
);

  logic [RECIP_W-1:0] recip_tbl [1 << SHRINK_W];

  for (genvar gi = 0; gi < (1 << SHRINK_W); gi++) begin : g_recip
    localparam int unsigned Lev   = levels_of(SHRINK_W'(gi));
    localparam int unsigned Recip = ((1 << DIV_SHIFT) + Lev - 1) / Lev;
    assign recip_tbl[gi] = RECIP_W'(Recip);
  end

  logic [MQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                accept;
  logic [LEV_W-1:0]    lev_now;

  logic               s1_valid_q;
  idx_split_t         s1_fg_q, s1_bg_q;
  logic [LEV_W-1:0]   s1_lev_q;
  logic [RECIP_W-1:0] s1_recip_q;
  logic [POS_W-1:0]   s1_pos_q;
  logic               s1_bad_q;

  logic      job_valid_q;
  pbre_job_t job_q, job_d;

  // credits cover both front stages and the queue
  assign full    = (cnt_q == MQ_CNT_W'(MQ_DEPTH));
  assign accept  = push && !full;
  assign lev_now = levels_of(data_i.shrink);
  assign cnt_d   = cnt_q + MQ_CNT_W'(accept) - MQ_CNT_W'(credit_i);

  always_comb begin
    job_d.position_bad = s1_bad_q;
    job_d.position     = s1_pos_q;
    job_d.levels       = s1_lev_q;
    job_d.recip        = s1_recip_q;
    job_d.fg_rgb       = decode_rgb(s1_fg_q);
    job_d.bg_rgb       = decode_rgb(s1_bg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      s1_valid_q  <= accept;
      job_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_fg_q    <= split_index(data_i.fg_index);
      s1_bg_q    <= split_index(data_i.bg_index);
      s1_lev_q   <= lev_now;
      s1_recip_q <= recip_tbl[data_i.shrink];
      s1_pos_q   <= data_i.position;
      s1_bad_q   <= (data_i.position > POS_W'(lev_now));
    end
    if (s1_valid_q) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  `PBRE_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= MQ_CNT_W'(MQ_DEPTH), "front credit overflow")
  `PBRE_ASSERT(a_credit_owned, clk_i, rst_ni, !credit_i || (cnt_q != '0), "credit without item")
  `PBRE_ASSERT(a_inflight, clk_i, rst_ni,
    (MQ_CNT_W'(s1_valid_q) + MQ_CNT_W'(job_valid_q)) <= cnt_q, "front stages exceed credits")

endmodule

// File: rtl/core/pbre_queue.sv
// short queue of classified items between front and back
module pbre_queue import pbre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pbre_job_t job_i,
  input  logic      pop_i,
  output logic      valid_o,
  output pbre_job_t job_o
);

  pbre_job_t           mem_q [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [MQ_CNT_W-1:0] cnt_q;
  logic                do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + MQ_CNT_W'(push_i) - MQ_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/core/pbre_back.sv
// back end: blends, divides by levels, quantizes and holds results for the consumer
`include "palette_blend_ramp_entry_unit_assert.svh"

module pbre_back import pbre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  pbre_job_t job_i,
  output logic      job_take_o,
  output logic      empty,
  input  logic      pop,
  output pbre_out_t data_o
);

  logic [OQ_CNT_W-1:0] ocnt_q;
  logic                take;
  logic                out_pop;

  logic [LEV_W-1:0]         inv_k, k;
  logic [2:0][NUM_W-1:0]    num_d;
  logic [2:0][CH_W-1:0]     mix_d;
  logic [GQ_W-1:0]          gq_d;
  logic [2:0][DIGIT_W-1:0]  dq_d;

  logic                     b1_valid_q, b1_bad_q;
  logic [2:0][NUM_W-1:0]    b1_num_q;
  logic [RECIP_W-1:0]       b1_recip_q;
  logic                     b2_valid_q, b2_bad_q;
  logic [2:0][CH_W-1:0]     b2_mix_q;
  logic                     b3_valid_q, b3_bad_q, b3_grey_q;
  logic [GQ_W-1:0]          b3_gq_q;
  logic [2:0][DIGIT_W-1:0]  b3_dq_q;

  pbre_out_t           res_d;
  logic [IDX_W-1:0]    cube_idx;
  pbre_out_t           fifo_q [OUT_DEPTH];
  logic [OQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [OQ_CNT_W-1:0] fcnt_q;

  // a credit for every item between the queue head and the consumer
  assign take       = job_valid_i && (ocnt_q != OQ_CNT_W'(OUT_DEPTH));
  assign job_take_o = take;
  assign empty      = (fcnt_q == '0);
  assign out_pop    = pop && !empty;
  assign data_o     = fifo_q[rptr_q];

  assign k     = LEV_W'(job_i.position);
  assign inv_k = job_i.levels - k;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num_d[ch] = NUM_W'(job_i.bg_rgb[ch]) * NUM_W'(inv_k) +
                  NUM_W'(job_i.fg_rgb[ch]) * NUM_W'(k);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mix_d[ch] = CH_W'((DPROD_W'(b1_num_q[ch]) * DPROD_W'(b1_recip_q)) >> DIV_SHIFT);
    end
  end

  always_comb begin
    gq_d = div_full_scale(QX_W'(b2_mix_q[0]) * QX_W'(GREY_LEVELS) + QX_W'(ROUND_HALF));
    for (int ch = 0; ch < 3; ch++) begin
      dq_d[ch] = DIGIT_W'(div_full_scale(QX_W'(b2_mix_q[ch]) * QX_W'(CUBE_STEPS) +
                                         QX_W'(ROUND_HALF)));
    end
  end

  always_comb begin
    cube_idx = IDX_W'(b3_dq_q[0]) * IDX_W'(CUBE_BASE * CUBE_BASE) +
               IDX_W'(b3_dq_q[1]) * IDX_W'(CUBE_BASE) +
               IDX_W'(b3_dq_q[2]) + IDX_W'(GREY_LEVELS + 1);
    res_d.position_bad = b3_bad_q;
    if (b3_bad_q) begin
      res_d.color_index = '0;
    end else if (b3_grey_q) begin
      res_d.color_index = IDX_W'(b3_gq_q);
    end else begin
      res_d.color_index = cube_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q     <= '0;
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      fcnt_q     <= '0;
    end else begin
      ocnt_q     <= ocnt_q + OQ_CNT_W'(take) - OQ_CNT_W'(out_pop);
      b1_valid_q <= take;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
      if (b3_valid_q) begin
        wptr_q <= (wptr_q == OQ_PTR_W'(OUT_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (out_pop) begin
        rptr_q <= (rptr_q == OQ_PTR_W'(OUT_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      fcnt_q <= fcnt_q + OQ_CNT_W'(b3_valid_q) - OQ_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      b1_num_q   <= num_d;
      b1_recip_q <= job_i.recip;
      b1_bad_q   <= job_i.position_bad;
    end
    if (b1_valid_q) begin
      b2_mix_q <= mix_d;
      b2_bad_q <= b1_bad_q;
    end
    if (b2_valid_q) begin
      b3_gq_q   <= gq_d;
      b3_dq_q   <= dq_d;
      b3_grey_q <= (b2_mix_q[0] == b2_mix_q[1]) && (b2_mix_q[1] == b2_mix_q[2]);
      b3_bad_q  <= b2_bad_q;
    end
    if (b3_valid_q) begin
      fifo_q[wptr_q] <= res_d;
    end
  end

  `PBRE_ASSERT(a_ocnt_bound, clk_i, rst_ni, ocnt_q <= OQ_CNT_W'(OUT_DEPTH), "back credit overflow")
  `PBRE_ASSERT(a_ocnt_track, clk_i, rst_ni,
    ocnt_q == fcnt_q + OQ_CNT_W'(b1_valid_q) + OQ_CNT_W'(b2_valid_q) + OQ_CNT_W'(b3_valid_q),
    "back credits out of step")
  `PBRE_ASSERT(a_no_overrun, clk_i, rst_ni,
    !b3_valid_q || (fcnt_q != OQ_CNT_W'(OUT_DEPTH)) || out_pop, "result fifo overrun")
  `PBRE_ASSERT(a_bad_zero, clk_i, rst_ni,
    empty || !data_o.position_bad || (data_o.color_index == '0), "flagged item not zeroed")
  `PBRE_ASSERT_NEXT(a_take_flows, clk_i, rst_ni, take, b1_valid_q, "taken item lost")

endmodule

// File: rtl/core/palette_blend_ramp_entry_unit.sv
// Palette blend ramp entry unit: takes a foreground index, a background index, a shrink
// factor and a ramp position, and returns the palette index of the blended color (grey
// ramp when all channels match, otherwise the color cube), or index 0 with position_bad
// set when the position lies beyond shrink squared (capped at 64) levels. Both sides look
// like queues. One item is taken every cycle when the consumer keeps up; a result is
// poppable once its item clears the queue and all stages. The front end decodes indices in
// two stages and holds up to four items with a short queue behind it; full rises when those
// four credits are used. The back end blends, divides by levels with a reciprocal multiply
// and quantizes in three stages, and buffers up to eight results for the consumer.
module palette_blend_ramp_entry_unit import pbre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  pbre_in_t  data_i,
  output logic      empty,
  input  logic      pop,
  output pbre_out_t data_o
);

  logic      f_valid;
  pbre_job_t f_job;
  logic      q_valid;
  pbre_job_t q_job;
  logic      q_take;

  pbre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_i      (data_i),
    .credit_i    (q_take),
    .job_valid_o (f_valid),
    .job_o       (f_job)
  );

  pbre_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .job_i   (f_job),
    .pop_i   (q_take),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  pbre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_take_o  (q_take),
    .empty       (empty),
    .pop         (pop),
    .data_o      (data_o)
  );

endmodule
